>>> src/set_assoc_lru_cache_model_core_defines.svh
// Shared assertion macros
`ifndef SET_ASSOC_LRU_CACHE_MODEL_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_CORE_DEFINES_SVH

// Checked outside reset
`define SALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset as well
`define SALC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/salc_pkg.sv
package salc_pkg;

  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_WIDTH = 64;
  localparam int TAG_WIDTH  = 32;
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int SET_W      = $clog2(MAX_SETS);
  localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  // request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;

  // outcome codes
  localparam logic [1:0] OC_HIT   = 2'd0;
  localparam logic [1:0] OC_MISS  = 2'd1;
  localparam logic [1:0] OC_EVICT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS        = 2'd2;

  // one memory word holds a whole set
  typedef struct packed {
    logic [MAX_WAYS-1:0]                valid;
    logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]   stamp;
  } row_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic       hit;
    logic       miss;
    logic       evict;
  } lk_res_t;

endpackage

>>> src/salc_lookup.sv
module salc_lookup
  import salc_pkg::*;
(
  input  row_t                 row,
  input  logic                 row_ok,
  input  logic [TAG_WIDTH-1:0] tag,
  input  logic [STAMP_W-1:0]   stamp,
  input  logic [3:0]           ways_in_use,
  output row_t                 new_row,
  output lk_res_t              res
);

  logic [3:0]          ways_eff;
  logic [MAX_WAYS-1:0] active;
  logic [MAX_WAYS-1:0] valid_eff;
  logic                hit_found;
  logic [WAY_W-1:0]    hit_way;
  logic                inv_found;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    lru_way;
  logic [WAY_W-1:0]    sel_way;

  always_comb begin
    ways_eff = ways_in_use;
    if (ways_in_use == 4'd0) begin
      ways_eff = 4'd1;
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      ways_eff = 4'(MAX_WAYS);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      active[i] = (i < int'(ways_eff));
    end
    valid_eff = row_ok ? row.valid : '0;
  end

  // lowest matching way and lowest free way
  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (active[i] && valid_eff[i] && (row.tag[i] == tag)) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(i);
      end
      if (active[i] && !valid_eff[i]) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(i);
      end
    end
  end

  // oldest stamp, strict compare keeps the lowest way on ties
  always_comb begin
    lru_way = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (active[i] && (row.stamp[i] < row.stamp[lru_way])) begin
        lru_way = WAY_W'(i);
      end
    end
  end

  always_comb begin
    if (hit_found) begin
      sel_way = hit_way;
    end else if (inv_found) begin
      sel_way = inv_way;
    end else begin
      sel_way = lru_way;
    end
    new_row                = row;
    new_row.valid          = valid_eff;
    new_row.valid[sel_way] = 1'b1;
    new_row.tag[sel_way]   = tag;
    new_row.stamp[sel_way] = stamp;

    res.hit   = hit_found;
    res.miss  = !hit_found;
    res.evict = !hit_found && !inv_found;
    if (hit_found) begin
      res.outcome = OC_HIT;
    end else if (inv_found) begin
      res.outcome = OC_MISS;
    end else begin
      res.outcome = OC_EVICT;
    end
  end

endmodule

>>> src/set_assoc_lru_cache_model_core.sv
// Set-associative cache model with LRU replacement. Each input word is a load,
// store or modify on a 64-bit address; every cache access returns one output
// word with its outcome and the running hit, miss and eviction totals, and a
// modify returns two words (last marks the second). An unknown request type
// is taken but gives no output word. Each access is a registered read of
// the whole set from the set memory followed by a step that compares the
// ways, picks the victim and writes the set back. The second access of a
// modify works on the set already held in registers. Per-set valid flops
// are cleared at reset, so no clearing pass is needed. A new input is
// taken while the last result still waits on the output; an access stalls only
// if the output register is still full when its result is ready.
module set_assoc_lru_cache_model_core
  import salc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [5:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            req_type,
  input  logic [ADDR_WIDTH-1:0] address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            outcome,
  output logic                  last,
  output logic [CNT_W-1:0]      hit_total,
  output logic [CNT_W-1:0]      miss_total,
  output logic [CNT_W-1:0]      eviction_total
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SECOND} state_t;

  state_t                state;
  logic [3:0]            set_bits;
  logic [5:0]            offset_bits;
  logic [3:0]            ways_in_use;

  logic [SET_W-1:0]      set_q;
  logic [TAG_WIDTH-1:0]  tag_q;
  logic                  modify_q;
  logic                  rv_q;
  row_t                  row_q;
  row_t                  rd_row;
  logic [MAX_SETS-1:0]   row_valid;
  logic [STAMP_W-1:0]    access_stamp;
  logic [CNT_W-1:0]      hit_count;
  logic [CNT_W-1:0]      miss_count;
  logic [CNT_W-1:0]      eviction_count;

  row_t                  mem [MAX_SETS];

  logic                  accept;
  logic                  out_free;
  logic                  work;
  logic                  final_acc;
  logic [6:0]            tag_shift;
  logic [ADDR_WIDTH-1:0] tag_full;
  logic [ADDR_WIDTH-1:0] off_full;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_c;
  logic [TAG_WIDTH-1:0]  tag_c;
  row_t                  lk_row;
  logic                  lk_ok;
  row_t                  new_row;
  lk_res_t               res;
  logic [CNT_W-1:0]      hit_next;
  logic [CNT_W-1:0]      miss_next;
  logic [CNT_W-1:0]      evict_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign work      = ((state == S_LOOK) || (state == S_SECOND)) && out_free;
  assign final_acc = (state == S_SECOND) || !modify_q;

  // address split
  always_comb begin
    tag_shift = 7'(set_bits) + 7'(offset_bits);
    tag_full  = tag_shift[6] ? '0 : (address >> tag_shift[5:0]);
    tag_c     = tag_full[TAG_WIDTH-1:0];
    off_full  = address >> offset_bits;
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(set_bits));
    end
    set_c = off_full[SET_W-1:0] & set_mask;
  end

  assign lk_row = (state == S_SECOND) ? row_q : rd_row;
  assign lk_ok  = (state == S_SECOND) ? 1'b1 : rv_q;

  salc_lookup u_lookup (
    .row         (lk_row),
    .row_ok      (lk_ok),
    .tag         (tag_q),
    .stamp       (access_stamp),
    .ways_in_use (ways_in_use),
    .new_row     (new_row),
    .res         (res)
  );

  assign hit_next   = hit_count + CNT_W'(res.hit);
  assign miss_next  = miss_count + CNT_W'(res.miss);
  assign evict_next = eviction_count + CNT_W'(res.evict);

  // set memory: read on accept, write back on each access
  always_ff @(posedge clk) begin
    if (work) begin
      mem[set_q] <= new_row;
    end
    if (accept) begin
      rd_row <= mem[set_c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 4'd0;
      offset_bits <= 6'd0;
      ways_in_use <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SET_BITS:    set_bits    <= cfg_data[3:0];
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_WAYS:        ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      row_valid      <= '0;
      access_stamp   <= '0;
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
    end else begin
      if (out_valid && out_ready && !work) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            access_stamp <= access_stamp + STAMP_W'(1);
            set_q        <= set_c;
            tag_q        <= tag_c;
            rv_q         <= row_valid[set_c];
            modify_q     <= (req_type == REQ_MODIFY);
            case (req_type) inside
              REQ_LOAD, REQ_STORE, REQ_MODIFY: state <= S_LOOK;
              default:                         state <= S_IDLE;
            endcase
          end
        end
        S_LOOK, S_SECOND: begin
          if (work) begin
            row_valid[set_q] <= 1'b1;
            row_q            <= new_row;
            hit_count        <= hit_next;
            miss_count       <= miss_next;
            eviction_count   <= evict_next;
            out_valid        <= 1'b1;
            outcome          <= res.outcome;
            last             <= final_acc;
            hit_total        <= hit_next;
            miss_total       <= miss_next;
            eviction_total   <= evict_next;
            state            <= final_acc ? S_IDLE : S_SECOND;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/salc_checker.sv
`include "set_assoc_lru_cache_model_core_defines.svh"

module salc_checker
  import salc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [1:0]            req_type,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            outcome,
  input logic                  last,
  input logic [CNT_W-1:0]      hit_total,
  input logic [CNT_W-1:0]      miss_total,
  input logic [CNT_W-1:0]      eviction_total
);

  // stalled output word holds
  `SALC_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(last) &&
      $stable(hit_total) && $stable(miss_total) && $stable(eviction_total),
    "output word changed while stalled")

  `SALC_ASSERT(a_outcome_code,
    out_valid |-> (outcome == OC_HIT) || (outcome == OC_MISS) || (outcome == OC_EVICT),
    "illegal outcome code")

  // a real access leaves the input side busy in the cycle after it is taken
  `SALC_ASSERT(a_busy_after_accept,
    in_valid && in_ready && ((req_type == REQ_LOAD) || (req_type == REQ_STORE) ||
      (req_type == REQ_MODIFY)) |=> !in_ready,
    "input taken again right after an access")

  // first word of a modify is shown only while the second access is pending
  `SALC_ASSERT_ALWAYS(a_pair_busy,
    !rst && out_valid && !last |-> !in_ready,
    "input ready while a modify is unfinished")

endmodule

bind set_assoc_lru_cache_model_core salc_checker u_salc_checker (.*);
